@@ hw/rtl/wpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  // Block sizing
  localparam int NUM_PATTERNS    = 4;
  localparam int PATTERN_MAX_LEN = 4;
  localparam int MAX_MATCHES     = 10;
  localparam int POSITION_BITS   = 16;

  localparam int CHAR_BITS     = 8;
  localparam int LEN_BITS      = 3;
  localparam int SLOT_BITS     = 4;
  localparam int INDEX_BITS    = 2;
  localparam int WINDOW_DEPTH  = PATTERN_MAX_LEN - 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [LEN_BITS-1:0] LEN_SAT = 3'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PATTERN_ZERO    = 3'd0,
    REG_PATTERN_ONE     = 3'd1,
    REG_PATTERN_TWO     = 3'd2,
    REG_PATTERN_THREE   = 3'd3,
    REG_PATTERN_LENGTHS = 3'd4
  } cfg_reg_t;

  typedef logic [CHAR_BITS-1:0] char_t;

  function automatic logic is_alnum(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic char_t to_lower(input char_t c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wpm_char_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wpm_char_if;
  import wpm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] text_char;
  logic                 end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wpm_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wpm_result_if;
  import wpm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    pattern_index;
  logic [POSITION_BITS-1:0] word_number;
  logic [SLOT_BITS-1:0]     occurrence_slot;
  logic                     last_of_run;

  modport source (output valid, output pattern_index, output word_number,
                  output occurrence_slot, output last_of_run, input ready);
  modport sink   (input valid, input pattern_index, input word_number,
                  input occurrence_slot, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/word_pattern_match_counter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Results: a closing byte's results are loaded into the pending register when the byte is
// accepted, then move to the output register one per cycle while that register is free or read.
// Throughput: one byte per cycle while no results are pending; a closing byte that yields
// results holds off the next byte while the pending results drain to the output register.
// Reset (synchronous, active high) clears patterns, lengths, window, flags, counts
// and the word counter.
module word_pattern_match_counter (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [wpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire [wpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  wpm_char_if.sink                          chars,
  wpm_result_if.source                      results
);
  import wpm_pkg::*;

  // Configuration, stored lowercased
  char_t [NUM_PATTERNS-1:0][PATTERN_MAX_LEN-1:0] patterns;
  logic  [NUM_PATTERNS*LEN_BITS-1:0]             pattern_lengths;

  // Word state
  char_t [WINDOW_DEPTH-1:0]                      window;
  logic  [LEN_BITS-1:0]                          len_seen;
  logic  [NUM_PATTERNS-1:0]                      found;
  logic  [NUM_PATTERNS-1:0][SLOT_BITS-1:0]       counts;
  logic  [POSITION_BITS-1:0]                     word_counter;

  // Results waiting for the output register
  logic  [NUM_PATTERNS-1:0]                      pend_mask;
  logic  [POSITION_BITS-1:0]                     pend_word;
  logic  [NUM_PATTERNS-1:0][SLOT_BITS-1:0]       pend_slot;

  // Output register
  logic                                          out_valid;
  logic  [INDEX_BITS-1:0]                        out_index;
  logic  [POSITION_BITS-1:0]                     out_word;
  logic  [SLOT_BITS-1:0]                         out_slot;
  logic                                          out_last;

  logic                          accept;
  logic                          alnum;
  char_t                         lc;
  logic  [LEN_BITS-1:0]          seen_inc;
  logic  [NUM_PATTERNS-1:0]      hit;
  logic  [NUM_PATTERNS-1:0]      found_next;
  logic                          close_word;
  logic  [NUM_PATTERNS-1:0]      emit;
  logic                          move;
  logic  [INDEX_BITS-1:0]        sel;
  logic  [NUM_PATTERNS-1:0]      rest;
  logic  [NUM_PATTERNS-1:0]      pend_mask_next;

  // Match the window plus the new character against each pattern
  always_comb begin
    logic [LEN_BITS-1:0] code;
    alnum    = is_alnum(chars.text_char);
    lc       = to_lower(chars.text_char);
    seen_inc = (len_seen < LEN_SAT) ? len_seen + 3'd1 : LEN_SAT;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      code = pattern_lengths[p*LEN_BITS +: LEN_BITS];
      case (code)
        3'd1: hit[p] = patterns[p][0] == lc;
        3'd2: hit[p] = patterns[p][1] == lc && patterns[p][0] == window[0];
        3'd3: hit[p] = patterns[p][2] == lc && patterns[p][1] == window[0] &&
                       patterns[p][0] == window[1];
        3'd4: hit[p] = patterns[p][3] == lc && patterns[p][2] == window[0] &&
                       patterns[p][1] == window[1] && patterns[p][0] == window[2];
        default: hit[p] = 1'b0;
      endcase
      hit[p] = hit[p] && alnum && (seen_inc >= code);
    end
    found_next = found | hit;
    close_word = (!alnum || chars.end_of_text) && (alnum || len_seen != '0);
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      emit[p] = close_word && found_next[p] &&
                (counts[p] < SLOT_BITS'(MAX_MATCHES));
    end
  end

  // Pick the lowest pending pattern for the output register
  always_comb begin
    sel = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (pend_mask[p]) begin
        sel = INDEX_BITS'(p);
      end
    end
    rest           = pend_mask & ~(NUM_PATTERNS'(1) << sel);
    move           = (pend_mask != '0) && (!out_valid || results.ready);
    pend_mask_next = move ? rest : pend_mask;
  end

  assign chars.ready = (pend_mask_next == '0);
  assign accept      = chars.valid && chars.ready;

  // Hold configuration; lowercase pattern bytes on write
  always_ff @(posedge clk) begin
    if (rst) begin
      patterns        <= '0;
      pattern_lengths <= '0;
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_BITS'(NUM_PATTERNS)) begin
        for (int k = 0; k < PATTERN_MAX_LEN; k++) begin
          patterns[cfg_index[INDEX_BITS-1:0]][k] <= to_lower(cfg_data[k*CHAR_BITS +: CHAR_BITS]);
        end
      end else if (cfg_index == REG_PATTERN_LENGTHS) begin
        pattern_lengths <= cfg_data[NUM_PATTERNS*LEN_BITS-1:0];
      end
    end
  end

  // Advance word state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      len_seen     <= '0;
      found        <= '0;
      counts       <= '0;
      word_counter <= '0;
    end else if (accept) begin
      if (close_word) begin
        window   <= '0;
        len_seen <= '0;
        found    <= '0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
          if (emit[p]) begin
            counts[p] <= counts[p] + SLOT_BITS'(1);
          end
        end
        if (word_counter != '1) begin
          word_counter <= word_counter + POSITION_BITS'(1);
        end
      end else if (alnum) begin
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
          window[i] <= window[i-1];
        end
        window[0] <= lc;
        len_seen  <= seen_inc;
        found     <= found_next;
      end
    end
  end

  // Load pending results of a closed word, drain one per cycle while the output register is free or read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (accept && emit != '0) begin
      pend_mask <= emit;
    end else begin
      pend_mask <= pend_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit != '0) begin
      pend_word <= word_counter;
      pend_slot <= counts;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_index <= sel;
      out_word  <= pend_word;
      out_slot  <= pend_slot[sel];
      out_last  <= (rest == '0);
    end
  end

  assign results.valid           = out_valid;
  assign results.pattern_index   = out_index;
  assign results.word_number     = out_word;
  assign results.occurrence_slot = out_slot;
  assign results.last_of_run     = out_last;

endmodule

`default_nettype wire
